FILE: hdl/fmhm_pkg.sv
// ----------------------------------------------------------------------------
// fmhm_pkg
// Types, register codes and reset values shared by the fan motor health
// monitor modules.
// ----------------------------------------------------------------------------
package fmhm_pkg;

  localparam int unsigned MaxMotors       = 3;
  localparam int unsigned MotorsPerBranch = 3;
  localparam int unsigned NumBranches     = 2;
  localparam int unsigned CntW            = 6;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOTORS_IN_UNIT     = 3'd0,
    CFG_CONNECT_THRESHOLD  = 3'd1,
    CFG_STARTUP_TICKS      = 3'd2,
    CFG_TACHO_PERSIST      = 3'd3,
    CFG_VOUT_ERR_PERSIST   = 3'd4,
    CFG_MIN_RPM            = 3'd5,
    CFG_MIN_VOUT_FOR_TACHO = 3'd6,
    CFG_OFF_SPEED          = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  motors_in_unit;
    logic [4:0]  connect_threshold;
    logic [5:0]  startup_ticks;
    logic [5:0]  tacho_persist;
    logic [5:0]  vout_err_persist;
    logic [13:0] min_rpm;
    logic [10:0] min_vout_for_tacho;
    logic [7:0]  off_speed;
  } fmhm_cfg_t;

  localparam fmhm_cfg_t CfgReset = '{
    motors_in_unit:     3'd6,
    connect_threshold:  5'd8,
    startup_ticks:      6'd36,
    tacho_persist:      6'd20,
    vout_err_persist:   6'd12,
    min_rpm:            14'd60,
    min_vout_for_tacho: 11'd195,
    off_speed:          8'd60
  };

  localparam logic [CntW-1:0] ConnectReset  = 6'd6;
  localparam logic [CntW-1:0] ConnectMargin = 6'd8;
  localparam logic [CntW-1:0] CntMax        = 6'd63;

  typedef struct packed {
    logic [7:0]  set_speed_return;
    logic [7:0]  set_speed_fresh;
    logic [10:0] vout_return;
    logic [10:0] vout_fresh;
    logic [2:0]  power_return;
    logic [2:0]  power_fresh;
    logic [13:0] rpm_return_0;
    logic [13:0] rpm_return_1;
    logic [13:0] rpm_return_2;
    logic [13:0] rpm_fresh_0;
    logic [13:0] rpm_fresh_1;
    logic [13:0] rpm_fresh_2;
  } fmhm_in_t;

  typedef struct packed {
    logic [6:0] status_return;
    logic [6:0] status_fresh;
    logic       monitoring_off;
  } fmhm_out_t;

  // per-tick control into a lane
  typedef struct packed {
    logic upd;
    logic off;
    logic enabled;
    logic powered;
  } lane_ctrl_t;

  // next status bits of one motor
  typedef struct packed {
    logic power;
    logic alarm;
  } lane_stat_t;

endpackage

FILE: hdl/fmhm_motor_lane.sv
// ----------------------------------------------------------------------------
// fmhm_motor_lane
// One motor: power-presence counter with hysteresis and tacho stall alarm.
// ----------------------------------------------------------------------------
module fmhm_motor_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fmhm_pkg::fmhm_cfg_t    cfg_i,
  input  fmhm_pkg::lane_ctrl_t   ctrl_i,
  input  logic [10:0]            vout_i,
  input  logic [13:0]            rpm_i,
  output fmhm_pkg::lane_stat_t   stat_o
);
  import fmhm_pkg::*;

  logic [CntW-1:0] conn_q, conn_d;
  logic [CntW-1:0] stall_q, stall_d;
  logic            power_q, power_d;
  logic            alarm_q, alarm_d;
  logic [CntW-1:0] conn_max;

  assign conn_max = {1'b0, cfg_i.connect_threshold} + ConnectMargin;

  always_comb begin
    conn_d  = conn_q;
    stall_d = stall_q;
    power_d = power_q;
    alarm_d = alarm_q;
    if (ctrl_i.upd) begin
      if (ctrl_i.off) begin
        stall_d = '0;
      end else begin
        if (ctrl_i.powered) begin
          if (conn_q < conn_max) conn_d = conn_q + 1'b1;
        end else if (conn_q != '0) begin
          conn_d = conn_q - 1'b1;
        end
        if (ctrl_i.enabled) begin
          if (conn_d >= {1'b0, cfg_i.connect_threshold}) begin
            power_d = 1'b1;
          end else if (conn_d <= 6'd1) begin
            power_d = 1'b0;
          end
          if (vout_i >= cfg_i.min_vout_for_tacho) begin
            if (rpm_i < cfg_i.min_rpm) begin
              if (stall_q < cfg_i.tacho_persist) begin
                stall_d = stall_q + 1'b1;
              end else begin
                alarm_d = 1'b1;
              end
            end else begin
              alarm_d = 1'b0;
              stall_d = '0;
            end
          end
        end else begin
          power_d = 1'b0;
          alarm_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q  <= ConnectReset;
      stall_q <= '0;
      power_q <= 1'b0;
      alarm_q <= 1'b0;
    end else begin
      conn_q  <= conn_d;
      stall_q <= stall_d;
      power_q <= power_d;
      alarm_q <= alarm_d;
    end
  end

  assign stat_o.power = power_d;
  assign stat_o.alarm = alarm_d;

endmodule

FILE: hdl/fmhm_volt_lane.sv
// ----------------------------------------------------------------------------
// fmhm_volt_lane
// One branch: drive voltage tracking check with persistence counter.
// ----------------------------------------------------------------------------
module fmhm_volt_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fmhm_pkg::fmhm_cfg_t  cfg_i,
  input  logic                 upd_i,
  input  logic                 off_i,
  input  logic [7:0]           set_i,
  input  logic [10:0]          vout_i,
  output logic                 verr_o
);
  import fmhm_pkg::*;

  // floor(v/3) for 8-bit v via reciprocal 171/512
  function automatic logic [6:0] div3(input logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd171;
    return p[15:9];
  endfunction

  logic [CntW-1:0] mm_q, mm_d;
  logic            verr_q, verr_d;
  logic [11:0]     cmd, vout_x, diff, tol;
  logic            mismatch;

  assign cmd      = {2'b00, set_i, 2'b00};
  assign vout_x   = {1'b0, vout_i};
  assign diff     = (cmd > vout_x) ? (cmd - vout_x) : (vout_x - cmd);
  assign tol      = 12'd4 + {5'b0, div3(set_i)};
  assign mismatch = diff > tol;

  always_comb begin
    mm_d   = mm_q;
    verr_d = verr_q;
    if (upd_i) begin
      if (off_i) begin
        verr_d = 1'b0;
      end else if (mismatch) begin
        if (mm_q < cfg_i.vout_err_persist) begin
          mm_d = mm_q + 1'b1;
        end else begin
          verr_d = 1'b1;
        end
      end else begin
        mm_d   = '0;
        verr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_q   <= '0;
      verr_q <= 1'b0;
    end else begin
      mm_q   <= mm_d;
      verr_q <= verr_d;
    end
  end

  assign verr_o = verr_d;

endmodule

FILE: hdl/fan_motor_health_monitor_core.sv
// ----------------------------------------------------------------------------
// fan_motor_health_monitor_core
// Monitoring tick for two fan branches: per-motor lanes, per-branch voltage
// lanes, status merge and a two-entry output buffer.
// ----------------------------------------------------------------------------
// Each result is registered in the output register, or in the skid entry if the output is held.
// Throughput: one tick per cycle while the skid entry is free; all lanes update in the accept cycle.
// Input stalls only when both output register and skid entry are full.
// Reset: async active low; registers to defaults, counters and status
// cleared, connect counters to 6.
module fan_motor_health_monitor_core #(
  parameter int unsigned MOTORS_PER_BRANCH = fmhm_pkg::MotorsPerBranch
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  fmhm_pkg::cfg_idx_e            cfg_index_i,
  input  logic [fmhm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fmhm_pkg::fmhm_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fmhm_pkg::fmhm_out_t           out_data_o
);
  import fmhm_pkg::*;

  fmhm_cfg_t       cfg_q;
  logic [CntW-1:0] startup_q, startup_d;
  logic            in_fire, out_fire, off;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MOTORS_IN_UNIT:     cfg_q.motors_in_unit     <= cfg_data_i[2:0];
        CFG_CONNECT_THRESHOLD:  cfg_q.connect_threshold  <= cfg_data_i[4:0];
        CFG_STARTUP_TICKS:      cfg_q.startup_ticks      <= cfg_data_i[5:0];
        CFG_TACHO_PERSIST:      cfg_q.tacho_persist      <= cfg_data_i[5:0];
        CFG_VOUT_ERR_PERSIST:   cfg_q.vout_err_persist   <= cfg_data_i[5:0];
        CFG_MIN_RPM:            cfg_q.min_rpm            <= cfg_data_i[13:0];
        CFG_MIN_VOUT_FOR_TACHO: cfg_q.min_vout_for_tacho <= cfg_data_i[10:0];
        CFG_OFF_SPEED:          cfg_q.off_speed          <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_fire = in_valid_i && in_ready_o;

  assign off = (in_data_i.set_speed_return < cfg_q.off_speed) &&
               (in_data_i.set_speed_fresh < cfg_q.off_speed) &&
               (startup_q >= cfg_q.startup_ticks);

  always_comb begin
    startup_d = startup_q;
    if (in_fire && !off && (startup_q <= cfg_q.startup_ticks) && (startup_q < CntMax)) begin
      startup_d = startup_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_q <= '0;
    end else begin
      startup_q <= startup_d;
    end
  end

  // lane inputs
  logic [NumBranches-1:0][10:0]               vout;
  logic [NumBranches-1:0][7:0]                set;
  logic [NumBranches-1:0][MaxMotors-1:0]      pwr;
  logic [NumBranches-1:0][MaxMotors-1:0][13:0] rpm;
  lane_stat_t [NumBranches-1:0][MaxMotors-1:0] stat;
  logic [NumBranches-1:0]                     verr;

  assign vout[0] = in_data_i.vout_return;
  assign vout[1] = in_data_i.vout_fresh;
  assign set[0]  = in_data_i.set_speed_return;
  assign set[1]  = in_data_i.set_speed_fresh;
  assign pwr[0]  = in_data_i.power_return;
  assign pwr[1]  = in_data_i.power_fresh;
  assign rpm[0][0] = in_data_i.rpm_return_0;
  assign rpm[0][1] = in_data_i.rpm_return_1;
  assign rpm[0][2] = in_data_i.rpm_return_2;
  assign rpm[1][0] = in_data_i.rpm_fresh_0;
  assign rpm[1][1] = in_data_i.rpm_fresh_1;
  assign rpm[1][2] = in_data_i.rpm_fresh_2;

  for (genvar gb = 0; gb < NumBranches; gb++) begin : g_branch
    fmhm_volt_lane u_volt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg_q),
      .upd_i  (in_fire),
      .off_i  (off),
      .set_i  (set[gb]),
      .vout_i (vout[gb]),
      .verr_o (verr[gb])
    );
    for (genvar gi = 0; gi < MaxMotors; gi++) begin : g_motor
      if (gi < MOTORS_PER_BRANCH) begin : g_lane
        lane_ctrl_t ctrl;
        assign ctrl.upd     = in_fire;
        assign ctrl.off     = off;
        assign ctrl.enabled = cfg_q.motors_in_unit[2:1] >= 2'(gi);
        assign ctrl.powered = pwr[gb][gi];
        fmhm_motor_lane u_motor (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .cfg_i  (cfg_q),
          .ctrl_i (ctrl),
          .vout_i (vout[gb]),
          .rpm_i  (rpm[gb][gi]),
          .stat_o (stat[gb][gi])
        );
      end else begin : g_none
        assign stat[gb][gi] = '0;
      end
    end
  end

  // merge
  fmhm_out_t res;
  logic [NumBranches-1:0][6:0] status;

  for (genvar gb = 0; gb < NumBranches; gb++) begin : g_merge
    assign status[gb] = {stat[gb][2].alarm, stat[gb][1].alarm, stat[gb][0].alarm,
                         verr[gb],
                         stat[gb][2].power, stat[gb][1].power, stat[gb][0].power};
  end

  assign res.status_return  = status[0];
  assign res.status_fresh   = status[1];
  assign res.monitoring_off = off;

  // output register plus skid entry
  fmhm_out_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;

  assign out_fire   = out_valid_q && out_ready_i;
  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      out_valid_q  <= skid_valid_q || in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output beat");

  a_off_clears_verr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && off) |-> (!res.status_return[3] && !res.status_fresh[3]))
    else $error("off tick left voltage error set");

  a_startup_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && !off) |=> $stable(startup_q))
    else $error("start-up counter moved without a monitored tick");

  a_skid_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_ready_i) |=> $stable(skid_q))
    else $error("skid entry overwritten");

endmodule
